// ===== sv/rpc_pkg.sv =====
// Shared types and constants for the restricted partition counter.
package rpc_pkg;

    localparam int MAX_SUM_DEF = 256;

    localparam int PART_W      = 8;
    localparam int TGT_W       = 9;
    localparam int COUNT_W     = 64;
    localparam int EXCL_DEPTH  = 256;
    localparam int EXCL_AW     = $clog2(EXCL_DEPTH);

    localparam int JOB_Q_DEPTH = 2;

    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int REG_IDX_W   = 1;

    localparam logic [REG_IDX_W-1:0] REG_TARGET_SUM = 1'b0;

    typedef struct packed {
        logic [TGT_W-1:0] target;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    typedef enum logic [1:0] {
        F_CLEAR,
        F_OPEN,
        F_HOLD
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_INIT,
        B_RUN,
        B_FLUSH,
        B_FETCH,
        B_EMIT
    } back_state_t;

endpackage

// ===== sv/rpc_if.sv =====
// Valid/ready channel interfaces for exclusion items and partition counts.
interface rpc_in_if;
    import rpc_pkg::*;

    logic              valid;
    logic              ready;
    logic [PART_W-1:0] excluded_part;
    logic              last_item;

    modport source (output valid, output excluded_part, output last_item, input ready);
    modport sink   (input valid, input excluded_part, input last_item, output ready);
endinterface

interface rpc_out_if;
    import rpc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] partition_count;

    modport source (output valid, output partition_count, input ready);
    modport sink   (input valid, input partition_count, output ready);
endinterface

// ===== sv/rpc_front.sv =====
// Front end: accepts exclusion items, keeps the exclusion map, queues a case on the last item.
module rpc_front (
    input  logic                        clk,
    input  logic                        rst_n,
    rpc_in_if.sink                      item_in,
    input  logic [rpc_pkg::TGT_W-1:0]   target,
    input  rpc_pkg::q_stat_t            q_stat,
    output logic                        push,
    output rpc_pkg::job_t               push_job,
    input  logic                        case_done,
    input  logic [rpc_pkg::EXCL_AW-1:0] map_idx,
    output logic                        map_bit
);
    import rpc_pkg::*;

    localparam logic [EXCL_AW-1:0] CLR_LAST = EXCL_AW'(EXCL_DEPTH - 1);

    front_state_t            state_reg;
    front_state_t            state_next;
    logic [EXCL_AW-1:0]      clr_idx_reg;
    logic [EXCL_AW-1:0]      clr_idx_next;
    logic                    map_mem [EXCL_DEPTH];
    logic                    map_wr_en;
    logic [EXCL_AW-1:0]      map_wr_addr;
    logic                    map_wr_bit;
    logic                    map_bit_reg;
    logic                    accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_CLEAR;
            clr_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        push          = 1'b0;
        item_in.ready = 1'b0;
        accept        = 1'b0;
        map_wr_en     = 1'b0;
        map_wr_addr   = clr_idx_reg;
        map_wr_bit    = 1'b0;
        case (state_reg)
            F_CLEAR:
            begin
                // sweep the map clear, one entry per cycle
                map_wr_en    = 1'b1;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == CLR_LAST)
                begin
                    state_next = F_OPEN;
                end
            end
            F_OPEN:
            begin
                item_in.ready = !q_stat.full;
                accept        = item_in.valid && !q_stat.full;
                if (accept)
                begin
                    if (item_in.excluded_part != '0)
                    begin
                        map_wr_en   = 1'b1;
                        map_wr_addr = item_in.excluded_part;
                        map_wr_bit  = 1'b1;
                    end
                    if (item_in.last_item)
                    begin
                        push       = 1'b1;
                        state_next = F_HOLD;
                    end
                end
            end
            F_HOLD:
            begin
                // hold the map until the counting pass no longer reads it
                if (case_done)
                begin
                    state_next = F_CLEAR;
                end
            end
            default:
            begin
                state_next = F_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (map_wr_en)
        begin
            map_mem[map_wr_addr] <= map_wr_bit;
        end
        map_bit_reg <= map_mem[map_idx];
    end

    assign push_job.target = target;
    assign map_bit         = map_bit_reg;

endmodule

// ===== sv/rpc_job_q.sv =====
// Short job queue between the front end and the counting engine.
module rpc_job_q (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rpc_pkg::job_t    push_job,
    input  logic             pop,
    output rpc_pkg::job_t    pop_job,
    output rpc_pkg::q_stat_t q_stat
);
    import rpc_pkg::*;

    localparam int QPW = (JOB_Q_DEPTH > 1) ? $clog2(JOB_Q_DEPTH) : 1;
    localparam int QCW = $clog2(JOB_Q_DEPTH + 1);
    localparam logic [QPW-1:0] PTR_LAST = QPW'(JOB_Q_DEPTH - 1);
    localparam logic [QCW-1:0] CNT_FULL = QCW'(JOB_Q_DEPTH);

    job_t           slots [JOB_Q_DEPTH];
    logic [QPW-1:0] wr_ptr_reg;
    logic [QPW-1:0] wr_ptr_next;
    logic [QPW-1:0] rd_ptr_reg;
    logic [QPW-1:0] rd_ptr_next;
    logic [QCW-1:0] cnt_reg;
    logic [QCW-1:0] cnt_next;
    logic           do_push;
    logic           do_pop;

    assign q_stat.empty = (cnt_reg == '0);
    assign q_stat.full  = (cnt_reg == CNT_FULL);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_job      = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== sv/rpc_back.sv =====
// Counting engine: bottom-up coin-change pass over the ways memory, one update per cycle.
module rpc_back #(
    parameter int MAX_SUM = rpc_pkg::MAX_SUM_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rpc_pkg::q_stat_t            q_stat,
    input  rpc_pkg::job_t               pop_job,
    output logic                        pop,
    output logic [rpc_pkg::EXCL_AW-1:0] map_idx,
    input  logic                        map_bit,
    output logic                        case_done,
    rpc_out_if.source                   result_out
);
    import rpc_pkg::*;

    localparam int AW = $clog2(MAX_SUM + 1);

    logic [COUNT_W-1:0] ways_mem [MAX_SUM + 1];

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [AW-1:0]      tgt_reg;
    logic [AW-1:0]      tgt_next;
    logic [AW-1:0]      s_reg;
    logic [AW-1:0]      s_next;
    logic [AW-1:0]      p_reg;
    logic [AW-1:0]      p_next;
    logic               deg_reg;
    logic               deg_next;

    logic               upd_v_reg;
    logic [AW-1:0]      upd_addr_reg;
    logic [AW-1:0]      lo_addr_reg;
    logic               last_wr_v_reg;
    logic [AW-1:0]      last_wr_addr_reg;
    logic [COUNT_W-1:0] last_wr_data_reg;

    logic [COUNT_W-1:0] rd_hi_reg;
    logic [COUNT_W-1:0] rd_lo_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic               iss;
    logic               rd_en;
    logic [AW-1:0]      rd_hi_addr;
    logic [AW-1:0]      rd_lo_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [COUNT_W-1:0] wr_data;
    logic [COUNT_W-1:0] hi_val;
    logic [COUNT_W-1:0] lo_val;
    logic [COUNT_W-1:0] sum;
    logic [31:0]        p_wide;
    logic [31:0]        p_next_wide;
    logic [31:0]        job_tgt_wide;
    logic               excl;

    // look up the exclusion of the next part from p_next, so that the registered map_bit belongs to p_reg
    assign p_wide       = 32'(p_reg);
    assign p_next_wide  = 32'(p_next);
    assign map_idx      = p_next_wide[EXCL_AW-1:0];
    assign excl         = (p_wide < EXCL_DEPTH) && map_bit;
    assign job_tgt_wide = 32'(pop_job.target);

    // bypass the write that lands at the same edge as the read
    assign hi_val = (last_wr_v_reg && last_wr_addr_reg == upd_addr_reg) ?
                    last_wr_data_reg : rd_hi_reg;
    assign lo_val = (last_wr_v_reg && last_wr_addr_reg == lo_addr_reg) ?
                    last_wr_data_reg : rd_lo_reg;
    assign sum    = hi_val + lo_val;

    always_comb
    begin
        state_next     = state_reg;
        tgt_next       = tgt_reg;
        s_next         = s_reg;
        p_next         = p_reg;
        deg_next       = deg_reg;
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        pop            = 1'b0;
        case_done      = 1'b0;
        iss            = 1'b0;
        rd_en          = 1'b0;
        rd_hi_addr     = s_reg;
        rd_lo_addr     = s_reg - p_reg;

        if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop      = 1'b1;
                    tgt_next = job_tgt_wide[AW-1:0];
                    s_next   = '0;
                    deg_next = (job_tgt_wide < 32'd2) || (job_tgt_wide > 32'(MAX_SUM));
                    state_next = deg_next ? B_EMIT : B_INIT;
                end
            end
            B_INIT:
            begin
                // seed one way to make zero, none for every other sum up to the target
                if (s_reg == tgt_reg)
                begin
                    p_next     = AW'(1);
                    s_next     = AW'(1);
                    state_next = B_RUN;
                end
                else
                begin
                    s_next = s_reg + 1'b1;
                end
            end
            B_RUN:
            begin
                if (p_reg == tgt_reg)
                begin
                    state_next = B_FLUSH;
                end
                else if (excl)
                begin
                    p_next = p_reg + 1'b1;
                    s_next = p_reg + 1'b1;
                end
                else
                begin
                    iss   = 1'b1;
                    rd_en = 1'b1;
                    if (s_reg == tgt_reg)
                    begin
                        p_next = p_reg + 1'b1;
                        s_next = p_reg + 1'b1;
                    end
                    else
                    begin
                        s_next = s_reg + 1'b1;
                    end
                end
            end
            B_FLUSH:
            begin
                state_next = B_FETCH;
            end
            B_FETCH:
            begin
                rd_en      = 1'b1;
                rd_hi_addr = tgt_reg;
                rd_lo_addr = tgt_reg;
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (!out_valid_reg || result_out.ready)
                begin
                    out_valid_next = 1'b1;
                    count_next     = deg_reg ? '0 : rd_hi_reg;
                    case_done      = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = s_reg;
        wr_data = '0;
        if (upd_v_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = upd_addr_reg;
            wr_data = sum;
        end
        else if (state_reg == B_INIT)
        begin
            wr_en   = 1'b1;
            wr_data = (s_reg == '0) ? COUNT_W'(1) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            upd_v_reg     <= 1'b0;
            last_wr_v_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            upd_v_reg     <= iss;
            last_wr_v_reg <= upd_v_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_reg          <= tgt_next;
        s_reg            <= s_next;
        p_reg            <= p_next;
        deg_reg          <= deg_next;
        count_reg        <= count_next;
        upd_addr_reg     <= rd_hi_addr;
        lo_addr_reg      <= rd_lo_addr;
        last_wr_addr_reg <= upd_addr_reg;
        last_wr_data_reg <= sum;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ways_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_hi_reg <= ways_mem[rd_hi_addr];
            rd_lo_reg <= ways_mem[rd_lo_addr];
        end
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.partition_count = count_reg;

endmodule

// ===== sv/restricted_partition_counter_core.sv =====
// Top level of the restricted partition counter: config register, front end, queue, engine.
//
//   channel      dir   payload                         handshake
//   item_in      in    excluded_part[7:0], last_item   valid/ready
//   result_out   out   partition_count[63:0]           valid/ready
//   apb          in    target_sum[8:0] at offset 0     psel/penable, pready tied high
//
// Exclusion items are taken one per cycle. A last item starts a case for target T (no
// counting pass when T is 0, 1 or above MAX_SUM), one ways-memory update per cycle for
// each part not excluded, set by the single write port of the ways memory. Items are
// held off until the count is in the output register and the exclusion map has been
// swept clear of all 256 entries; the same sweep runs after rst_n. The ways memory
// needs no clearing. A stalled result_out holds the count while the next case loads.
module restricted_partition_counter_core #(
    parameter int MAX_SUM = rpc_pkg::MAX_SUM_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rpc_pkg::APB_AW-1:0] paddr,
    input  logic [rpc_pkg::APB_DW-1:0] pwdata,
    output logic [rpc_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    rpc_in_if.sink                     item_in,
    rpc_out_if.source                  result_out
);
    import rpc_pkg::*;

    logic [TGT_W-1:0]     target_reg;
    logic [TGT_W-1:0]     target_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_req;

    q_stat_t              q_stat;
    job_t                 push_job;
    job_t                 pop_job;
    logic                 push;
    logic                 pop;
    logic                 case_done;
    logic [EXCL_AW-1:0]   map_idx;
    logic                 map_bit;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_req  = psel && penable && pwrite;

    always_comb
    begin
        target_next = target_reg;
        if (wr_req && reg_idx == REG_TARGET_SUM)
        begin
            target_next = pwdata[TGT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_TARGET_SUM)
        begin
            prdata = APB_DW'(target_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else
        begin
            target_reg <= target_next;
        end
    end

    rpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (item_in),
        .target    (target_reg),
        .q_stat    (q_stat),
        .push      (push),
        .push_job  (push_job),
        .case_done (case_done),
        .map_idx   (map_idx),
        .map_bit   (map_bit)
    );

    rpc_job_q u_job_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_stat   (q_stat)
    );

    rpc_back #(
        .MAX_SUM (MAX_SUM)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .pop_job    (pop_job),
        .pop        (pop),
        .map_idx    (map_idx),
        .map_bit    (map_bit),
        .case_done  (case_done),
        .result_out (result_out)
    );

endmodule
